[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// check a property every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[design/ppti_pkg.sv]
package ppti_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int LAST_MAX    = TABLE_DEPTH - 1;

   localparam int DIST_W  = 32;
   localparam int WORD_W  = 32;
   localparam int ENTRY_W = 10;
   localparam int LAST_W  = 10;
   localparam int FRAC_W  = 16;
   localparam int CSR_W   = 32;
   localparam int CSR_A_W = 2;

   localparam logic [CSR_A_W-1:0] CSR_R_MIN      = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_INV_DR     = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_LAST_INDEX = 2'd2;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BELOW  = 2'd1,
      STATUS_BEYOND = 2'd2,
      STATUS_LOADED = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] force_word;
      logic signed [WORD_W-1:0] energy_word;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr_a;
      logic [IDX_W-1:0] rd_addr_b;
   } tbl_ctrl_type;

endpackage

[design/ppti_if.sv]
interface ppti_req_if;
   import ppti_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [DIST_W-1:0]        distance;
   logic [ENTRY_W-1:0]       entry_index;
   logic signed [WORD_W-1:0] force_word;
   logic signed [WORD_W-1:0] energy_word;

   modport source (output valid, func, distance, entry_index, force_word, energy_word,
                   input ready);
   modport sink (input valid, func, distance, entry_index, force_word, energy_word,
                 output ready);
endinterface

interface ppti_rsp_if;
   import ppti_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] force_out;
   logic signed [WORD_W-1:0] energy_out;
   status_type               status;

   modport source (output valid, force_out, energy_out, status, input ready);
   modport sink (input valid, force_out, energy_out, status, output ready);
endinterface

[design/ppti_table_mem.sv]
module ppti_table_mem (
   input  logic                    clock,
   input  ppti_pkg::tbl_ctrl_type  ctrl,
   output ppti_pkg::entry_type     rd_a,
   output ppti_pkg::entry_type     rd_b
);
   import ppti_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_a_ff <= mem[ctrl.rd_addr_a];
         rd_b_ff <= mem[ctrl.rd_addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

[design/pair_potential_table_interpolator_core.sv]
// Linear interpolation over a 1024-entry force/energy table. One transaction is
// accepted per cycle unless the pipeline is backed up, and results leave on the response
// channel in order; a stalled response backs up the pipeline stage by stage, so
// empty stages keep taking transactions. The pipeline stages hold the 32x32 position
// multiplier, the two-address registered table read and the 33x17 slope
// multipliers. Loads write the table at the same stage where evaluations read it,
// so an evaluation always sees exactly the loads accepted before it. The table is
// not cleared at reset: entries must be loaded before they are evaluated. Write
// configuration only while no transaction is in flight.
module pair_potential_table_interpolator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ppti_pkg::CSR_A_W-1:0]   csr_index,
   input  logic [ppti_pkg::CSR_W-1:0]     csr_wr_data,
   ppti_req_if.sink                       req_ch,
   ppti_rsp_if.source                     rsp_ch
);
   import ppti_pkg::*;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W+1:0] v);
      logic signed [WORD_W+1:0] hi;
      logic signed [WORD_W+1:0] lo;
      hi = (WORD_W+2)'($signed({1'b0, {(WORD_W-1){1'b1}}}));
      lo = (WORD_W+2)'($signed({1'b1, {(WORD_W-1){1'b0}}}));
      if (v > hi) begin
         return hi[WORD_W-1:0];
      end else if (v < lo) begin
         return lo[WORD_W-1:0];
      end else begin
         return v[WORD_W-1:0];
      end
   endfunction

   logic [DIST_W-1:0] r_min_ff;
   logic [CSR_W-1:0]  inv_dr_ff;
   logic [LAST_W-1:0] last_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_min_ff      <= '0;
         inv_dr_ff     <= CSR_W'(65536);
         last_index_ff <= LAST_W'(1023);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_R_MIN:      r_min_ff      <= csr_wr_data;
            CSR_INV_DR:     inv_dr_ff     <= csr_wr_data;
            CSR_LAST_INDEX: last_index_ff <= csr_wr_data[LAST_W-1:0];
            default: ;
         endcase
      end
   end

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en, s5_en, s6_en;

   assign s6_en = !s6_valid_ff || rsp_ch.ready;
   assign s5_en = !s5_valid_ff || s6_en;
   assign s4_en = !s4_valid_ff || s5_en;
   assign s3_en = !s3_valid_ff || s4_en;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_ch.ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req_ch.valid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
         if (s5_en) s5_valid_ff <= s4_valid_ff;
         if (s6_en) s6_valid_ff <= s5_valid_ff;
      end
   end

   // stage 1: offset from r_min
   logic               s1_func_ff;
   logic               s1_below_ff;
   logic [DIST_W-1:0]  s1_diff_ff;
   logic [ENTRY_W-1:0] s1_idx_ff;
   entry_type          s1_entry_ff;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_func_ff              <= req_ch.func;
         s1_below_ff             <= req_ch.distance < r_min_ff;
         s1_diff_ff              <= req_ch.distance - r_min_ff;
         s1_idx_ff               <= req_ch.entry_index;
         s1_entry_ff.force_word  <= req_ch.force_word;
         s1_entry_ff.energy_word <= req_ch.energy_word;
      end
   end

   // stage 2: table position
   logic                       s2_func_ff;
   logic                       s2_below_ff;
   logic [DIST_W+CSR_W-1:0]    s2_pos_ff;
   logic [ENTRY_W-1:0]         s2_idx_ff;
   entry_type                  s2_entry_ff;

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_func_ff  <= s1_func_ff;
         s2_below_ff <= s1_below_ff;
         s2_pos_ff   <= (DIST_W+CSR_W)'(s1_diff_ff) * (DIST_W+CSR_W)'(inv_dr_ff);
         s2_idx_ff   <= s1_idx_ff;
         s2_entry_ff <= s1_entry_ff;
      end
   end

   // stage 3: classify, issue table access
   localparam int POS_W = DIST_W + CSR_W;
   localparam int K_W   = POS_W - 40;

   logic [K_W-1:0] k_in;
   logic [31:0]    limit_in;
   logic           beyond_in;
   logic           in_table_in;
   status_type     s3_status_in;

   assign k_in        = s2_pos_ff[POS_W-1:40];
   assign limit_in    = (32'(last_index_ff) > 32'(LAST_MAX)) ? 32'(LAST_MAX)
                                                             : 32'(last_index_ff);
   assign beyond_in   = (32'(k_in) + 32'd1) > limit_in;
   assign in_table_in = 32'(s2_idx_ff) < 32'(TABLE_DEPTH);

   always_comb begin
      if (s2_func_ff == FUNC_LOAD) begin
         s3_status_in = STATUS_LOADED;
      end else if (s2_below_ff) begin
         s3_status_in = STATUS_BELOW;
      end else if (beyond_in) begin
         s3_status_in = STATUS_BEYOND;
      end else begin
         s3_status_in = STATUS_OK;
      end
   end

   status_type        s3_status_ff;
   logic              s3_wr_ff;
   logic [IDX_W-1:0]  s3_wr_addr_ff;
   logic [IDX_W-1:0]  s3_rd_addr_ff;
   logic [FRAC_W-1:0] s3_frac_ff;
   entry_type         s3_entry_ff;

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_status_ff  <= s3_status_in;
         s3_wr_ff      <= (s2_func_ff == FUNC_LOAD) && in_table_in;
         s3_wr_addr_ff <= IDX_W'(s2_idx_ff);
         s3_rd_addr_ff <= IDX_W'(k_in);
         s3_frac_ff    <= s2_pos_ff[39:24];
         s3_entry_ff   <= s2_entry_ff;
      end
   end

   tbl_ctrl_type tbl_ctrl;
   entry_type    tbl_a;
   entry_type    tbl_b;

   assign tbl_ctrl.wr_en     = s3_valid_ff && s4_en && s3_wr_ff;
   assign tbl_ctrl.wr_addr   = s3_wr_addr_ff;
   assign tbl_ctrl.wr_data   = s3_entry_ff;
   assign tbl_ctrl.rd_en     = s4_en;
   assign tbl_ctrl.rd_addr_a = s3_rd_addr_ff;
   assign tbl_ctrl.rd_addr_b = s3_rd_addr_ff + IDX_W'(1);

   ppti_table_mem u_table (
      .clock (clock),
      .ctrl  (tbl_ctrl),
      .rd_a  (tbl_a),
      .rd_b  (tbl_b)
   );

   // stage 4: table words arrive
   status_type        s4_status_ff;
   logic [FRAC_W-1:0] s4_frac_ff;

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_status_ff <= s3_status_ff;
         s4_frac_ff   <= s3_frac_ff;
      end
   end

   // stage 5: slope times fraction
   localparam int DIFF_W = WORD_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;

   logic signed [DIFF_W-1:0] diff_f_in;
   logic signed [DIFF_W-1:0] diff_e_in;
   logic signed [FRAC_W:0]   frac_s_in;

   assign diff_f_in = DIFF_W'(tbl_b.force_word) - DIFF_W'(tbl_a.force_word);
   assign diff_e_in = DIFF_W'(tbl_b.energy_word) - DIFF_W'(tbl_a.energy_word);
   assign frac_s_in = $signed({1'b0, s4_frac_ff});

   status_type               s5_status_ff;
   entry_type                s5_base_ff;
   logic signed [PROD_W-1:0] s5_prod_f_ff;
   logic signed [PROD_W-1:0] s5_prod_e_ff;

   always_ff @(posedge clock) begin
      if (s5_en) begin
         s5_status_ff <= s4_status_ff;
         s5_base_ff   <= tbl_a;
         s5_prod_f_ff <= PROD_W'(diff_f_in) * PROD_W'(frac_s_in);
         s5_prod_e_ff <= PROD_W'(diff_e_in) * PROD_W'(frac_s_in);
      end
   end

   // stage 6: base plus floored step, saturate; zero unless status is OK
   logic signed [WORD_W+1:0] sum_f_in;
   logic signed [WORD_W+1:0] sum_e_in;

   assign sum_f_in = (WORD_W+2)'(s5_base_ff.force_word)
                   + (WORD_W+2)'(s5_prod_f_ff >>> FRAC_W);
   assign sum_e_in = (WORD_W+2)'(s5_base_ff.energy_word)
                   + (WORD_W+2)'(s5_prod_e_ff >>> FRAC_W);

   status_type               s6_status_ff;
   logic signed [WORD_W-1:0] s6_force_ff;
   logic signed [WORD_W-1:0] s6_energy_ff;

   always_ff @(posedge clock) begin
      if (s6_en) begin
         s6_status_ff <= s5_status_ff;
         if (s5_status_ff == STATUS_OK) begin
            s6_force_ff  <= sat_word(sum_f_in);
            s6_energy_ff <= sat_word(sum_e_in);
         end else begin
            s6_force_ff  <= '0;
            s6_energy_ff <= '0;
         end
      end
   end

   assign rsp_ch.valid      = s6_valid_ff;
   assign rsp_ch.status     = s6_status_ff;
   assign rsp_ch.force_out  = s6_force_ff;
   assign rsp_ch.energy_out = s6_energy_ff;

endmodule

[design/ppti_checker.sv]
`include "assert_macros.svh"

module ppti_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input ppti_pkg::status_type             rsp_status,
   input logic signed [ppti_pkg::WORD_W-1:0] rsp_force_out,
   input logic signed [ppti_pkg::WORD_W-1:0] rsp_energy_out
);
   import ppti_pkg::*;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_force_out) && $stable(rsp_energy_out))
   `ASSERT_CLK(a_zero_on_fault, clock, reset, rsp_valid && rsp_status != STATUS_OK |-> rsp_force_out == '0 && rsp_energy_out == '0)
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `ASSERT_CLK(a_ready_when_drained, clock, reset, !rsp_valid |-> req_ready)

endmodule

bind pair_potential_table_interpolator_core ppti_checker u_ppti_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_force_out  (rsp_ch.force_out),
   .rsp_energy_out (rsp_ch.energy_out)
);

[dv/tb_pair_potential_table_interpolator_core.sv]
module tb_pair_potential_table_interpolator_core;
   import ppti_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic                     func;
      logic [DIST_W-1:0]        distance;
      logic [ENTRY_W-1:0]       entry_index;
      logic signed [WORD_W-1:0] force_word;
      logic signed [WORD_W-1:0] energy_word;
   } pair_request_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] force_out;
      logic signed [WORD_W-1:0] energy_out;
      status_type               status;
   } pair_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic               csr_wr_en;
   logic [CSR_A_W-1:0] csr_index;
   logic [CSR_W-1:0]   csr_wr_data;

   ppti_req_if req_ch();
   ppti_rsp_if rsp_ch();

   pair_potential_table_interpolator_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   logic [DIST_W-1:0] cfg_r_min      = '0;
   logic [CSR_W-1:0]  cfg_inv_dr     = 32'h0001_0000;
   logic [LAST_W-1:0] cfg_last_index = 10'd1023;

   logic signed [WORD_W-1:0] force_samples  [TABLE_DEPTH];
   logic signed [WORD_W-1:0] energy_samples [TABLE_DEPTH];
   bit                       entry_loaded   [TABLE_DEPTH];

   pair_request_type requests_to_send[$];
   pair_result_type  awaited_results[$];
   pair_request_type on_bus;
   pair_result_type  want_result;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int phase_items    = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint table_slot(input logic [DIST_W-1:0] sep,
                                         output logic [FRAC_W-1:0] frac);
      logic [DIST_W-1:0] offset;
      logic [63:0]       pos;
      frac = '0;
      if (sep < cfg_r_min) return -1;
      offset = sep - cfg_r_min;
      pos = {32'd0, offset} * {32'd0, cfg_inv_dr};
      frac = pos[39:24];
      return longint'(pos[63:40]);
   endfunction

   function automatic logic signed [WORD_W-1:0] blend(input logic signed [WORD_W-1:0] lo,
                                                      input logic signed [WORD_W-1:0] hi,
                                                      input logic [FRAC_W-1:0] frac);
      longint sum;
      sum = longint'(lo) + (((longint'(hi) - longint'(lo)) * longint'({1'b0, frac})) >>> 16);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[WORD_W-1:0];
   endfunction

   function automatic pair_result_type compute_potential(input pair_request_type item);
      pair_result_type   res;
      longint            slot;
      logic [FRAC_W-1:0] frac;
      res.force_out  = '0;
      res.energy_out = '0;
      res.status     = STATUS_OK;
      if (item.func == FUNC_LOAD) begin
         force_samples[item.entry_index]  = item.force_word;
         energy_samples[item.entry_index] = item.energy_word;
         res.status = STATUS_LOADED;
      end else begin
         slot = table_slot(item.distance, frac);
         if (slot < 0) begin
            res.status = STATUS_BELOW;
         end else if (slot + 1 > longint'(cfg_last_index)) begin
            res.status = STATUS_BEYOND;
         end else begin
            res.force_out  = blend(force_samples[slot], force_samples[slot+1], frac);
            res.energy_out = blend(energy_samples[slot], energy_samples[slot+1], frac);
         end
      end
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 2000)) - 32'd1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DIST_W-1:0] distance_at(input int k);
      logic [63:0] pos;
      logic [63:0] offset;
      logic [63:0] room;
      pos  = (64'(k) << 40) | {24'd0, 8'($urandom), 32'($urandom)};
      room = {32'd0, 32'hFFFF_FFFF - cfg_r_min};
      if (cfg_inv_dr == 0) offset = {32'd0, 32'($urandom)};
      else offset = pos / {32'd0, cfg_inv_dr};
      if (offset > room) offset = room;
      return cfg_r_min + offset[31:0];
   endfunction

   task automatic push_load(input int idx, input logic [WORD_W-1:0] fw,
                            input logic [WORD_W-1:0] ew);
      pair_request_type item;
      item.func        = FUNC_LOAD;
      item.distance    = $urandom;
      item.entry_index = idx[ENTRY_W-1:0];
      item.force_word  = fw;
      item.energy_word = ew;
      entry_loaded[idx] = 1'b1;
      requests_to_send.push_back(item);
      phase_items++;
   endtask

   // load any entry the evaluation would read before sending it
   task automatic push_eval(input logic [DIST_W-1:0] sep);
      pair_request_type  item;
      longint            slot;
      logic [FRAC_W-1:0] frac;
      slot = table_slot(sep, frac);
      if (slot >= 0 && slot + 1 <= longint'(cfg_last_index)) begin
         if (!entry_loaded[slot]) push_load(int'(slot), random_word(), random_word());
         if (!entry_loaded[slot+1]) push_load(int'(slot + 1), random_word(), random_word());
      end
      item.func        = FUNC_EVAL;
      item.distance    = sep;
      item.entry_index = ENTRY_W'($urandom_range(0, TABLE_DEPTH - 1));
      item.force_word  = $urandom;
      item.energy_word = $urandom;
      requests_to_send.push_back(item);
      phase_items++;
   endtask

   task automatic fill_phase(input int count);
      int pick;
      int lim;
      lim = int'(cfg_last_index);
      phase_items = 0;
      while (phase_items < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            push_load($urandom_range(0, TABLE_DEPTH - 1), random_word(), random_word());
         end else if (pick < 80) begin
            push_eval(distance_at((lim >= 1) ? $urandom_range(0, lim - 1) : 0));
         end else if (pick < 85) begin
            push_eval(distance_at(lim + $urandom_range(0, 2)));
         end else if (pick < 93 && cfg_r_min != 0) begin
            push_eval($urandom_range(0, cfg_r_min - 1));
         end else begin
            push_eval($urandom);
         end
      end
   endtask

   task automatic settle();
      while (requests_to_send.size() != 0 || req_ch.valid || awaited_results.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic configure(input logic [DIST_W-1:0] r_min_v, input logic [CSR_W-1:0] inv_dr_v,
                            input logic [LAST_W-1:0] last_v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_R_MIN;
      csr_wr_data <= r_min_v;
      @(posedge clock);
      csr_index   <= CSR_INV_DR;
      csr_wr_data <= inv_dr_v;
      @(posedge clock);
      csr_index   <= CSR_LAST_INDEX;
      csr_wr_data <= 32'(last_v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_r_min      = r_min_v;
      cfg_inv_dr     = inv_dr_v;
      cfg_last_index = last_v;
   endtask

   task automatic run_phase(input logic [DIST_W-1:0] r_min_v, input logic [CSR_W-1:0] inv_dr_v,
                            input logic [LAST_W-1:0] last_v, input int send_pct,
                            input int recv_pct, input int count);
      settle();
      configure(r_min_v, inv_dr_v, last_v);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      fill_phase(count);
   endtask

   // driver: hold the transaction until accepted, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            awaited_results.push_back(compute_potential(on_bus));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               on_bus = requests_to_send.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.func        <= on_bus.func;
               req_ch.distance    <= on_bus.distance;
               req_ch.entry_index <= on_bus.entry_index;
               req_ch.force_word  <= on_bus.force_word;
               req_ch.energy_word <= on_bus.energy_word;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t unexpected result: expected none, actual force %h energy %h status %0d",
                        $time, rsp_ch.force_out, rsp_ch.energy_out, rsp_ch.status);
               mismatch_count++;
            end else begin
               want_result = awaited_results.pop_front();
               if (rsp_ch.force_out !== want_result.force_out) begin
                  $display("%0t force_out: expected %h actual %h", $time,
                           want_result.force_out, rsp_ch.force_out);
                  mismatch_count++;
               end
               if (rsp_ch.energy_out !== want_result.energy_out) begin
                  $display("%0t energy_out: expected %h actual %h", $time,
                           want_result.energy_out, rsp_ch.energy_out);
                  mismatch_count++;
               end
               if (rsp_ch.status !== want_result.status) begin
                  $display("%0t status: expected %0d actual %0d", $time,
                           want_result.status, rsp_ch.status);
                  mismatch_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      csr_wr_en          = 1'b0;
      csr_index          = CSR_R_MIN;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_LOAD;
      req_ch.distance    = '0;
      req_ch.entry_index = '0;
      req_ch.force_word  = '0;
      req_ch.energy_word = '0;
      rsp_ch.ready       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      configure(32'd1, 32'h0004_0000, 10'd1023);
      @(negedge clock);
      push_load(0, 32'h7FFF_FFFF, 32'h8000_0000);
      push_load(1, 32'h8000_0000, 32'h7FFF_FFFF);
      push_load(1022, 32'h0000_0000, 32'hFFFF_FFFF);
      push_load(1023, 32'h7FFF_FFFF, 32'h8000_0000);
      push_load(512, random_word(), random_word());
      push_eval(32'h0000_0000);
      push_eval(32'h0000_0001);
      push_eval(32'h0020_0001);
      push_eval(32'hFF80_0001);
      push_eval(32'hFFC0_0000);
      push_eval(32'hFFC0_0001);
      push_eval(32'hFFFF_FFFF);
      push_eval(32'h8000_3039);
      push_load(0, 32'h0000_0000, 32'h0000_0000);
      push_eval(32'h0010_0001);

      run_phase(32'd0, 32'h0001_0000, 10'd1023, 0, 0, 200);
      run_phase($urandom_range(0, 32'h00FF_FFFF), 32'h0004_0000, 10'd1023, 62, 0, 200);
      run_phase(32'h8000_0000, 32'hFFFF_FFFF, 10'd1, 0, 62, 180);
      run_phase(32'hFFFF_FFFF, $urandom, 10'd500, 24, 24, 150);
      run_phase($urandom, 32'd0, 10'd700, 0, 0, 150);
      run_phase($urandom_range(0, 32'h0FFF_FFFF), 32'h0002_0000, 10'd0, 62, 0, 150);
      run_phase($urandom_range(0, 32'h3FFF_FFFF), $urandom_range(32'h4000, 32'h0010_0000),
                10'($urandom_range(1, 1023)), 0, 62, 250);
      run_phase($urandom, $urandom, 10'($urandom_range(1, 1023)), 24, 24, 250);
      run_phase(32'd0, 32'h0004_0000, 10'd1023, 24, 24, 250);
      run_phase(32'd1, 32'h0010_0000, 10'd1023, 0, 0, 200);
      settle();

      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
